/* hdl/rppc_pkg.sv */
// ----------------------------------------------------------------------------
// rppc_pkg: shared types and constants of the relay/precharge controller
// Transaction layouts, register map, state record and fixed timing constants.
// ----------------------------------------------------------------------------
package rppc_pkg;

  // Fixed timing and sizing constants
  localparam int DEBOUNCE_TICKS = 10;
  localparam int HORN_TICKS     = 500;
  localparam int AUX_CELLS      = 4;
  localparam int OVERLAP_TICKS  = 10;

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Input transaction kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  // Transmit kinds
  typedef enum logic [1:0] {
    TX_NONE       = 2'd0,
    TX_DISCONNECT = 2'd1,
    TX_BRAKE      = 2'd2,
    TX_TELEMETRY  = 2'd3
  } tx_kind_t;

  // Precharge sequence phase
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_PRECHARGE = 2'd1,
    PH_OVERLAP   = 2'd2
  } phase_t;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_DISCONNECT_ID = 3'd0,
    REG_HORN_ID       = 3'd1,
    REG_TEMP_ID_A     = 3'd2,
    REG_TEMP_ID_B     = 3'd3,
    REG_TEMP_ID_C     = 3'd4,
    REG_TEMP_LEVEL    = 3'd5,
    REG_PRECHARGE     = 3'd6,
    REG_SEND_PERIOD   = 3'd7
  } reg_idx_t;

  // Debounce counter slots
  localparam int DB_ARRAY = 0;
  localparam int DB_MOTOR = 1;
  localparam int DB_BRAKE = 2;

  typedef struct packed {
    logic [10:0] disconnect_cmd_id;
    logic [10:0] horn_cmd_id;
    logic [10:0] temp_msg_id_a;
    logic [10:0] temp_msg_id_b;
    logic [10:0] temp_msg_id_c;
    logic [7:0]  temp_warning_level;
    logic [12:0] precharge_ticks;
    logic [15:0] send_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        array_switch;
    logic        motor_sw;
    logic        brake_sw;
    logic        tx_ready;
    logic [10:0] msg_id;
    logic [3:0]  msg_len;
    logic [63:0] msg_data;
    logic [31:0] aux_cells;
    logic [7:0]  dcdc_temp;
  } item_t;

  typedef struct packed {
    logic        array_relay;
    logic        motor_relay;
    logic        precharge_relay;
    logic        horn_drive;
    logic        led_drive;
    tx_kind_t    tx_kind;
    logic [63:0] tx_data;
    logic        tripped;
  } result_t;

  typedef struct packed {
    logic            array_closed;
    logic            motor_closed;
    logic            brake_held;
    logic            battery_safe;
    logic            trip_latch;
    logic            send_pending;
    logic            led_level;
    logic            heartbeat;
    logic [15:0]     period_count;
    logic [2:0][3:0] debounce_count;
    logic [12:0]     precharge_count;
    phase_t          precharge_phase;
    logic [9:0]      horn_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    array_closed:    1'b0,
    motor_closed:    1'b0,
    brake_held:      1'b0,
    battery_safe:    1'b1,
    trip_latch:      1'b0,
    send_pending:    1'b0,
    led_level:       1'b0,
    heartbeat:       1'b0,
    period_count:    16'd0,
    debounce_count:  '0,
    precharge_count: 13'd0,
    precharge_phase: PH_IDLE,
    horn_count:      10'd0
  };

endpackage

/* hdl/rppc_ifs.sv */
// ----------------------------------------------------------------------------
// rppc_ifs: stream channels of the relay/precharge controller
// Input transaction channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rppc_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        array_switch;
  logic        motor_sw;
  logic        brake_sw;
  logic        tx_ready;
  logic [10:0] msg_id;
  logic [3:0]  msg_len;
  logic [63:0] msg_data;
  logic [31:0] aux_cells;
  logic [7:0]  dcdc_temp;

  modport source (
    output valid, op, array_switch, motor_sw, brake_sw, tx_ready,
           msg_id, msg_len, msg_data, aux_cells, dcdc_temp,
    input  ready
  );
  modport sink (
    input  valid, op, array_switch, motor_sw, brake_sw, tx_ready,
           msg_id, msg_len, msg_data, aux_cells, dcdc_temp,
    output ready
  );
endinterface

interface rppc_result_if;
  logic        valid;
  logic        ready;
  logic        array_relay;
  logic        motor_relay;
  logic        precharge_relay;
  logic        horn_drive;
  logic        led_drive;
  logic [1:0]  tx_kind;
  logic [63:0] tx_data;
  logic        tripped;

  modport source (
    output valid, array_relay, motor_relay, precharge_relay, horn_drive,
           led_drive, tx_kind, tx_data, tripped,
    input  ready
  );
  modport sink (
    input  valid, array_relay, motor_relay, precharge_relay, horn_drive,
           led_drive, tx_kind, tx_data, tripped,
    output ready
  );
endinterface

/* hdl/rppc_regs.sv */
// ----------------------------------------------------------------------------
// rppc_regs: configuration register file
// APB-style write/read of the eight controller registers.
// ----------------------------------------------------------------------------
module rppc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppc_pkg::ADDR_W-1:0] paddr,
  input  logic [rppc_pkg::DATA_W-1:0] pwdata,
  output logic [rppc_pkg::DATA_W-1:0] prdata,
  output rppc_pkg::cfg_t              cfg
);

  localparam int ADDR_HI = rppc_pkg::ADDR_W - 1;

  rppc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = rppc_pkg::reg_idx_t'(paddr[ADDR_HI:2]);
  assign wr_en = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disconnect_cmd_id  <= 11'd0;
      cfg.horn_cmd_id        <= 11'd0;
      cfg.temp_msg_id_a      <= 11'd0;
      cfg.temp_msg_id_b      <= 11'd0;
      cfg.temp_msg_id_c      <= 11'd0;
      cfg.temp_warning_level <= 8'd60;
      cfg.precharge_ticks    <= 13'd2000;
      cfg.send_period_ticks  <= 16'd1000;
    end else if (wr_en) begin
      unique case (idx)
        rppc_pkg::REG_DISCONNECT_ID: cfg.disconnect_cmd_id  <= pwdata[10:0];
        rppc_pkg::REG_HORN_ID:       cfg.horn_cmd_id        <= pwdata[10:0];
        rppc_pkg::REG_TEMP_ID_A:     cfg.temp_msg_id_a      <= pwdata[10:0];
        rppc_pkg::REG_TEMP_ID_B:     cfg.temp_msg_id_b      <= pwdata[10:0];
        rppc_pkg::REG_TEMP_ID_C:     cfg.temp_msg_id_c      <= pwdata[10:0];
        rppc_pkg::REG_TEMP_LEVEL:    cfg.temp_warning_level <= pwdata[7:0];
        rppc_pkg::REG_PRECHARGE:     cfg.precharge_ticks    <= pwdata[12:0];
        rppc_pkg::REG_SEND_PERIOD:   cfg.send_period_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      rppc_pkg::REG_DISCONNECT_ID: prdata = 32'(cfg.disconnect_cmd_id);
      rppc_pkg::REG_HORN_ID:       prdata = 32'(cfg.horn_cmd_id);
      rppc_pkg::REG_TEMP_ID_A:     prdata = 32'(cfg.temp_msg_id_a);
      rppc_pkg::REG_TEMP_ID_B:     prdata = 32'(cfg.temp_msg_id_b);
      rppc_pkg::REG_TEMP_ID_C:     prdata = 32'(cfg.temp_msg_id_c);
      rppc_pkg::REG_TEMP_LEVEL:    prdata = 32'(cfg.temp_warning_level);
      rppc_pkg::REG_PRECHARGE:     prdata = 32'(cfg.precharge_ticks);
      rppc_pkg::REG_SEND_PERIOD:   prdata = 32'(cfg.send_period_ticks);
      default:                     prdata = '0;
    endcase
  end

endmodule

/* hdl/rppc_step.sv */
// ----------------------------------------------------------------------------
// rppc_step: next-state and result logic for one transaction
// Tick handling (timers, precharge, debounce, telemetry) and message decode.
// ----------------------------------------------------------------------------
module rppc_step #(
  parameter int DEBOUNCE_TICKS = rppc_pkg::DEBOUNCE_TICKS,
  parameter int HORN_TICKS     = rppc_pkg::HORN_TICKS,
  parameter int AUX_CELLS      = rppc_pkg::AUX_CELLS
) (
  input  rppc_pkg::cfg_t    cfg,
  input  rppc_pkg::state_t  st,
  input  rppc_pkg::item_t   item,
  output rppc_pkg::state_t  st_next,
  output rppc_pkg::result_t res
);

  typedef struct packed {
    logic       fire;
    logic [3:0] count;
  } settle_t;

  // One debounce step: count while a change is wanted, fire at the limit
  function automatic settle_t settle(input logic [3:0] count, input logic want);
    settle_t    r;
    logic [3:0] inc;
    inc = count + 4'd1;
    r.fire  = 1'b0;
    r.count = 4'd0;
    if (want) begin
      if (inc >= 4'(DEBOUNCE_TICKS)) begin
        r.fire = 1'b1;
      end else begin
        r.count = inc;
      end
    end
    return r;
  endfunction

  settle_t            db_a;
  settle_t            db_m;
  settle_t            db_b;
  logic [12:0]        pc_inc;
  logic               want_a;
  logic               want_m;
  logic               temp_hot;
  logic               temp_id;
  logic [63:0]        page;
  rppc_pkg::tx_kind_t kind;

  // Temperature check over the valid bytes; lengths above eight cover all
  always_comb begin
    temp_hot = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (item.msg_len > 4'(i) && item.msg_data[8*i +: 8] >= cfg.temp_warning_level) begin
        temp_hot = 1'b1;
      end
    end
  end

  assign temp_id = (item.msg_id == cfg.temp_msg_id_a) ||
                   (item.msg_id == cfg.temp_msg_id_b) ||
                   (item.msg_id == cfg.temp_msg_id_c);
  assign pc_inc  = st.precharge_count + 13'd1;

  // Main update
  always_comb begin
    st_next = st;
    kind    = rppc_pkg::TX_NONE;
    page    = '0;
    want_a  = 1'b0;
    want_m  = 1'b0;
    db_a    = '0;
    db_m    = '0;
    db_b    = '0;

    if (item.op == rppc_pkg::OP_TICK) begin
      // Telemetry period and LED
      if (st.period_count >= cfg.send_period_ticks) begin
        st_next.period_count = 16'd0;
        st_next.led_level    = !st.led_level;
        st_next.send_pending = 1'b1;
      end else begin
        st_next.period_count = st.period_count + 16'd1;
      end

      // Horn countdown
      if (st.horn_count != 10'd0) begin
        st_next.horn_count = st.horn_count - 10'd1;
      end

      // Precharge sequence
      if (st.precharge_phase == rppc_pkg::PH_PRECHARGE) begin
        if (pc_inc >= cfg.precharge_ticks) begin
          st_next.motor_closed    = 1'b1;
          st_next.precharge_phase = rppc_pkg::PH_OVERLAP;
          st_next.precharge_count = 13'd0;
        end else begin
          st_next.precharge_count = pc_inc;
        end
      end else if (st.precharge_phase != rppc_pkg::PH_IDLE) begin
        if (pc_inc >= 13'(rppc_pkg::OVERLAP_TICKS)) begin
          st_next.precharge_phase = rppc_pkg::PH_IDLE;
          st_next.precharge_count = 13'd0;
        end else begin
          st_next.precharge_count = pc_inc;
        end
      end

      if (!st.trip_latch) begin
        if (st_next.send_pending && item.tx_ready) begin
          // Telemetry page; debouncing holds this tick
          for (int i = 0; i < 4; i++) begin
            if (i < AUX_CELLS) begin
              page[8*i +: 8] = item.aux_cells[8*i +: 8];
            end
          end
          page[39:32] = item.dcdc_temp;
          page[40]    = st_next.array_closed;
          page[48]    = st_next.motor_closed;
          page[56]    = st.heartbeat;
          st_next.heartbeat    = !st.heartbeat;
          st_next.send_pending = 1'b0;
          kind = rppc_pkg::TX_TELEMETRY;
        end else begin
          // Array switch
          want_a = (item.array_switch && !st.array_closed && st.battery_safe) ||
                   (!item.array_switch && st.array_closed);
          db_a = settle(st.debounce_count[rppc_pkg::DB_ARRAY], want_a);
          st_next.debounce_count[rppc_pkg::DB_ARRAY] = db_a.count;
          if (db_a.fire) begin
            st_next.array_closed = item.array_switch;
          end

          // Motor switch, ignored while the sequence runs
          if (st_next.precharge_phase == rppc_pkg::PH_IDLE) begin
            want_m = item.motor_sw != st_next.motor_closed;
            db_m = settle(st.debounce_count[rppc_pkg::DB_MOTOR], want_m);
            st_next.debounce_count[rppc_pkg::DB_MOTOR] = db_m.count;
            if (db_m.fire) begin
              if (item.motor_sw) begin
                st_next.precharge_phase = rppc_pkg::PH_PRECHARGE;
                st_next.precharge_count = 13'd0;
              end else begin
                st_next.motor_closed = 1'b0;
              end
            end
          end

          // Brake switch
          db_b = settle(st.debounce_count[rppc_pkg::DB_BRAKE],
                        item.brake_sw != st.brake_held);
          st_next.debounce_count[rppc_pkg::DB_BRAKE] = db_b.count;
          if (db_b.fire) begin
            st_next.brake_held = item.brake_sw;
            kind = rppc_pkg::TX_BRAKE;
          end
        end
      end
    end else if (!st.trip_latch) begin
      // Message decode: disconnect, then horn, then temperature
      if (item.msg_id == cfg.disconnect_cmd_id) begin
        st_next.array_closed = 1'b0;
        st_next.trip_latch   = 1'b1;
        kind = rppc_pkg::TX_DISCONNECT;
      end else if (item.msg_id == cfg.horn_cmd_id) begin
        st_next.horn_count = 10'(HORN_TICKS);
      end else if (temp_id) begin
        if (temp_hot) begin
          st_next.battery_safe = 1'b0;
          st_next.array_closed = 1'b0;
        end else if (!st.array_closed && item.array_switch) begin
          st_next.battery_safe = 1'b1;
          st_next.array_closed = 1'b1;
        end
      end
    end
  end

  // Result drive levels after the update
  always_comb begin
    res.array_relay     = st_next.array_closed;
    res.motor_relay     = st_next.motor_closed;
    res.precharge_relay = st_next.precharge_phase != rppc_pkg::PH_IDLE;
    res.horn_drive      = st_next.horn_count != 10'd0;
    res.led_drive       = st_next.led_level;
    res.tx_kind         = kind;
    res.tx_data         = page;
    res.tripped         = st_next.trip_latch;
  end

endmodule

/* hdl/rppc_core.sv */
// ----------------------------------------------------------------------------
// rppc_core: input register, controller state and result register
// Two-register pipeline; state advances when the input stage moves forward.
// ----------------------------------------------------------------------------
module rppc_core #(
  parameter int DEBOUNCE_TICKS = rppc_pkg::DEBOUNCE_TICKS,
  parameter int HORN_TICKS     = rppc_pkg::HORN_TICKS,
  parameter int AUX_CELLS      = rppc_pkg::AUX_CELLS
) (
  input  logic              clk,
  input  logic              rst,
  input  rppc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rppc_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output rppc_pkg::result_t out_res
);

  logic              stg_valid;
  rppc_pkg::item_t   stg_item;
  rppc_pkg::state_t  st;
  rppc_pkg::state_t  st_next;
  rppc_pkg::result_t res_next;
  logic              advance;

  // Input stage moves when the result register is free or being drained
  assign advance  = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || advance;

  rppc_step #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
    .HORN_TICKS     (HORN_TICKS),
    .AUX_CELLS      (AUX_CELLS)
  ) u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (stg_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
      st        <= rppc_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        stg_valid <= in_valid;
      end
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item <= in_item;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

endmodule

/* hdl/relay_precharge_power_controller_top.sv */
// ----------------------------------------------------------------------------
// relay_precharge_power_controller_top: array/motor relay and precharge control
// Top level with stream channels and the APB-style configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   item   - input channel; each transaction is a 1 ms tick (op 0) or a
//            received bus message (op 1) together with switch levels,
//            transmit-ready flag and telemetry readings.
//   result - one transaction per input: relay drives, horn, LED, the message
//            to transmit (tx_kind/tx_data) and the trip latch.
//   APB    - eight registers at byte address 4*index; write only while idle.
// Path: an input that is taken is held in the input register; its result is
//   then registered in the result register, from which it can be taken.
// Throughput: one transaction per clock while result is taken; the single-pass
//   update between the input register and the result register sets this figure.
// Stall: when result is not taken, the result register holds, the input
//   register fills, and item.ready drops until the result drains.
// Reset (rst, synchronous): pipeline empty, relays open, battery marked safe,
//   timers cleared, registers at their default values.
// ----------------------------------------------------------------------------
module relay_precharge_power_controller_top #(
  parameter int DEBOUNCE_TICKS = rppc_pkg::DEBOUNCE_TICKS,
  parameter int HORN_TICKS     = rppc_pkg::HORN_TICKS,
  parameter int AUX_CELLS      = rppc_pkg::AUX_CELLS
) (
  input  logic                        clk,
  input  logic                        rst,
  rppc_item_if.sink                   item,
  rppc_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppc_pkg::ADDR_W-1:0] paddr,
  input  logic [rppc_pkg::DATA_W-1:0] pwdata,
  output logic [rppc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  rppc_pkg::cfg_t    cfg;
  rppc_pkg::item_t   in_item;
  rppc_pkg::result_t out_res;

  assign pready = 1'b1;

  // Gather the input channel into one record
  always_comb begin
    in_item.op           = item.op;
    in_item.array_switch = item.array_switch;
    in_item.motor_sw     = item.motor_sw;
    in_item.brake_sw     = item.brake_sw;
    in_item.tx_ready     = item.tx_ready;
    in_item.msg_id       = item.msg_id;
    in_item.msg_len      = item.msg_len;
    in_item.msg_data     = item.msg_data;
    in_item.aux_cells    = item.aux_cells;
    in_item.dcdc_temp    = item.dcdc_temp;
  end

  rppc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rppc_core #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
    .HORN_TICKS     (HORN_TICKS),
    .AUX_CELLS      (AUX_CELLS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_item   (in_item),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  // Spread the result record onto the output channel
  assign result.array_relay     = out_res.array_relay;
  assign result.motor_relay     = out_res.motor_relay;
  assign result.precharge_relay = out_res.precharge_relay;
  assign result.horn_drive      = out_res.horn_drive;
  assign result.led_drive       = out_res.led_drive;
  assign result.tx_kind         = out_res.tx_kind;
  assign result.tx_data         = out_res.tx_data;
  assign result.tripped         = out_res.tripped;

`ifndef SYNTHESIS
  // A latched trip keeps the array open
  a_trip_array_open: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.tripped |-> !result.array_relay)
    else $error("array relay closed while tripped");

  // Only a telemetry transaction carries a page
  a_page_only_telemetry: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.tx_kind != rppc_pkg::TX_TELEMETRY) |-> result.tx_data == 64'd0)
    else $error("tx_data nonzero outside telemetry");

  // A tripped controller sends no brake or telemetry messages
  a_trip_no_traffic: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.tripped |->
      (result.tx_kind != rppc_pkg::TX_BRAKE) && (result.tx_kind != rppc_pkg::TX_TELEMETRY))
    else $error("message sent while tripped");
`endif

endmodule
